// ===== sv/bitrld_pkg.sv =====
// Shared types and constants for the bitonal run-length decoder.
// Used by the front end, the back end and the top level; no dependencies.
`default_nettype none

package bitrld_pkg;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int CHUNK_W   = 8;
    localparam int LEN_W     = 7;
    localparam int PIX_W     = 32;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] LIT_LAST_IDX  = 3'd5;
    localparam logic [IDX_W-1:0] PAIR_LAST_IDX = 3'd1;
    localparam logic [IDX_W-1:0] LONG_LAST_IDX = 3'd0;
    localparam logic [LEN_W-1:0] LONG_RUN_BASE = 7'd8;

    typedef enum logic [1:0] {
        KIND_LITERAL,
        KIND_PAIR,
        KIND_LONG
    } t_kind;

    // One classified chunk waiting in the queue
    typedef struct packed {
        logic               sof;
        t_kind              kind;
        logic [CHUNK_W-1:0] chunk;
    } t_entry;

    // Control from the configuration side to the back end
    typedef struct packed {
        logic stall;
        logic refresh;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== sv/bitrld_front.sv =====
// Front end: accepts chunk bytes, classifies the chunk type and queues them.
// Depends on bitrld_pkg.
`default_nettype none

module bitrld_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_valid,
    output logic                               o_s_ready,
    input  wire logic [bitrld_pkg::CHUNK_W-1:0] i_s_data,
    input  wire logic                          i_s_sof,
    output bitrld_pkg::t_entry                 o_entry,
    output logic                               o_valid,
    input  wire logic                          i_pop
);

    bitrld_pkg::t_entry r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    bitrld_pkg::t_entry n_entry;
    logic               push;

    always_comb begin
        n_entry.sof   = i_s_sof;
        n_entry.chunk = i_s_data;
        unique case (i_s_data[7:6])
            2'b00:   n_entry.kind = bitrld_pkg::KIND_LITERAL;
            2'b01:   n_entry.kind = bitrld_pkg::KIND_PAIR;
            default: n_entry.kind = bitrld_pkg::KIND_LONG;
        endcase
    end

    assign o_s_ready = (r_cnt != 2'd2);
    assign push      = i_s_valid && o_s_ready;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_entry   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_entry;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue popped while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !i_pop |=> (r_cnt == 2'd2))
        else $error("full queue lost an entry");

endmodule

`default_nettype wire

// ===== sv/bitrld_back.sv =====
// Back end: expands one queued chunk into runs, one run per cycle unless a configuration stall
// or output back-pressure holds it, clips against the pixels left in the image and drives the output register.
// Depends on bitrld_pkg.
`default_nettype none

module bitrld_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bitrld_pkg::t_entry             i_entry,
    input  wire logic                           i_valid,
    output logic                                o_pop,
    input  wire bitrld_pkg::t_ctrl              i_ctrl,
    input  wire logic [bitrld_pkg::PIX_W-1:0]   i_total,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [7:0]                          o_out_data,
    output logic                                o_out_user,
    output logic                                o_out_last
);

    localparam int PW = bitrld_pkg::PIX_W;
    localparam int LW = bitrld_pkg::LEN_W;

    logic [bitrld_pkg::IDX_W-1:0] r_idx;
    logic [PW-1:0]                r_left;
    logic [PW-1:0]                r_done;
    logic                         r_out_valid;
    logic                         r_color;
    logic [LW-1:0]                r_len;
    logic                         r_img_done;
    logic                         r_last;

    logic                         use_sof;
    logic [PW-1:0]                cur_left;
    logic [PW-1:0]                cur_done;
    logic                         run_color;
    logic [LW-1:0]                run_len;
    logic [bitrld_pkg::IDX_W-1:0] last_idx;
    logic [LW-1:0]                take;
    logic [PW-1:0]                n_left;
    logic [PW-1:0]                n_done;
    logic [PW:0]                  refresh_diff;
    logic                         out_free;
    logic                         go;
    logic                         empty_left;
    logic                         emit;
    logic                         run_last;

    always_comb begin
        use_sof  = (r_idx == '0) && i_entry.sof;
        cur_left = use_sof ? i_total : r_left;
        cur_done = use_sof ? '0 : r_done;

        unique case (i_entry.kind)
            bitrld_pkg::KIND_LITERAL: begin
                run_color = i_entry.chunk[bitrld_pkg::LIT_LAST_IDX - r_idx];
                run_len   = LW'(1);
                last_idx  = bitrld_pkg::LIT_LAST_IDX;
            end
            bitrld_pkg::KIND_PAIR: begin
                last_idx = bitrld_pkg::PAIR_LAST_IDX;
                if (r_idx == '0) begin
                    run_color = i_entry.chunk[5];
                    run_len   = LW'(i_entry.chunk[4:2]) + LW'(1);
                end else begin
                    run_color = ~i_entry.chunk[5];
                    run_len   = LW'(i_entry.chunk[1:0]) + LW'(1);
                end
            end
            default: begin
                run_color = i_entry.chunk[6];
                run_len   = LW'(i_entry.chunk[5:0]) + bitrld_pkg::LONG_RUN_BASE;
                last_idx  = bitrld_pkg::LONG_LAST_IDX;
            end
        endcase

        // Clip to the pixels left in the image
        take       = (cur_left < PW'(run_len)) ? cur_left[LW-1:0] : run_len;
        n_left     = cur_left - PW'(take);
        n_done     = cur_done + PW'(take);
        empty_left = (cur_left == '0);

        out_free = !r_out_valid || i_out_ready;
        go       = i_valid && !i_ctrl.stall && out_free;
        emit     = go && !empty_left;
        // A later run exists only while pixels remain
        run_last = (r_idx == last_idx) || (n_left == '0);
        o_pop    = go && (empty_left || run_last);

        refresh_diff = {1'b0, i_total} - {1'b0, r_done};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_left      <= PW'(1);
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.refresh) begin
                r_left <= refresh_diff[PW] ? '0 : refresh_diff[PW-1:0];
            end else if (go) begin
                if (empty_left) begin
                    r_left <= cur_left;
                    r_done <= cur_done;
                    r_idx  <= '0;
                end else begin
                    r_left <= n_left;
                    r_done <= n_done;
                    r_idx  <= run_last ? '0 : r_idx + 1'b1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_color    <= run_color;
            r_len      <= take;
            r_img_done <= (n_left == '0);
            r_last     <= run_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_len, r_color};
    assign o_out_user  = r_img_done;
    assign o_out_last  = r_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= bitrld_pkg::LIT_LAST_IDX) else $error("run index out of range");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_len != '0)) else $error("zero-length run emitted");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_img_done |-> r_last) else $error("image end not last run");
    a_no_go_in_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.refresh |-> !go) else $error("run processed during refresh");

endmodule

`default_nettype wire

// ===== sv/bitonal_run_length_decoder.sv =====
// Bitonal run-length decoder, top level: config registers, image size product.
// The first run of a chunk passes through the queue and then the output register.
// Runs: one run per cycle from the back end while neither the output nor the configuration
// holds it; a literal chunk gives six runs, a pair two, a long run one, a fully clipped
// chunk none; a clipped chunk ends at the run that uses up the image.
// Reset: synchronous; width, height and image pixel total 1, pixels done 0, queue and output empty.
// Depends on bitrld_pkg, bitrld_front and bitrld_back.
`default_nettype none

module bitonal_run_length_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] chunk_byte
    input  wire logic        s_axis_tuser,   // [0] start_of_image
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] run_color, [7:1] run_length
    output logic             m_axis_tuser,   // [0] image_done
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0]                    r_width;
    logic [15:0]                    r_height;
    logic [bitrld_pkg::PIX_W-1:0]   r_total;
    logic [1:0]                     r_cfg_pipe;

    bitrld_pkg::t_entry             q_entry;
    logic                           q_valid;
    logic                           q_pop;
    bitrld_pkg::t_ctrl              ctrl;

    // Hold the back end until the product and the pixels left are rebuilt
    assign ctrl.stall   = i_cfg_we || (r_cfg_pipe != 2'b00);
    assign ctrl.refresh = r_cfg_pipe[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 16'd1;
            r_height   <= 16'd1;
            r_total    <= bitrld_pkg::PIX_W'(1);
            r_cfg_pipe <= 2'b00;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bitrld_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    bitrld_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default:                      r_width  <= r_width;
                endcase
            end
            r_total    <= {16'd0, r_width} * {16'd0, r_height};
            r_cfg_pipe <= {r_cfg_pipe[0], i_cfg_we};
        end
    end

    bitrld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_data  (s_axis_tdata),
        .i_s_sof   (s_axis_tuser),
        .o_entry   (q_entry),
        .o_valid   (q_valid),
        .i_pop     (q_pop)
    );

    bitrld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (q_entry),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_ctrl      (ctrl),
        .i_total     (r_total),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/bitonal_run_length_decoder_tb.sv =====
// Self-checking testbench for bitonal_run_length_decoder: directed and random chunk streams,
// with a built-in run predictor and an in-order scoreboard on the run output stream.
// Depends on bitrld_pkg and the decoder RTL only.
`default_nettype none

module bitonal_run_length_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CHUNK_LITERAL = 2'b00;
    localparam logic [1:0] CHUNK_PAIR    = 2'b01;
    localparam int         DRAIN_CYCLES  = 16;
    localparam int         MAX_REPORTS   = 40;

    typedef struct packed {
        logic                         color;
        logic [bitrld_pkg::LEN_W-1:0] length;
        logic                         done;
        logic                         last;
    } t_run;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_tvalid      = 1'b0;
    logic [7:0]  s_tdata       = 8'h00;
    logic        s_tuser       = 1'b0;
    logic        m_tready      = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_idx       = bitrld_pkg::CFG_IMAGE_WIDTH;
    logic [15:0] cfg_data      = 16'h0000;

    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire [7:0]   m_axis_tdata;
    wire         m_axis_tuser;
    wire         m_axis_tlast;

    // Predictor state
    logic [15:0] img_width  = 16'd1;
    logic [15:0] img_height = 16'd1;
    logic [31:0] pix_count  = 32'd0;
    t_run        runs_expected[$];

    int          err_count      = 0;
    int          chunks_decoded = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    int          hold_left      = 0;

    always #2 i_clk = ~i_clk;

    bitonal_run_length_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    function automatic longint unsigned image_pixels();
        return longint'(img_width) * longint'(img_height);
    endfunction

    function automatic bit image_complete();
        return longint'(pix_count) >= image_pixels();
    endfunction

    // Clip one run to the pixels left in the image; drop it if nothing is left
    task automatic append_run(input logic color, input int unsigned len);
        longint unsigned total;
        longint unsigned left;
        longint unsigned take;
        t_run r;
        total = image_pixels();
        left  = (longint'(pix_count) >= total) ? 0 : total - longint'(pix_count);
        take  = (len < left) ? len : left;
        if (take == 0) return;
        pix_count = pix_count + take[31:0];
        r.color  = color;
        r.length = take[bitrld_pkg::LEN_W-1:0];
        r.done   = (longint'(pix_count) == total);
        r.last   = 1'b0;
        runs_expected.push_back(r);
    endtask

    task automatic decode_chunk(input logic [7:0] b, input logic sof);
        int first;
        first = runs_expected.size();
        if (sof) pix_count = 32'd0;
        case (b[7:6])
            CHUNK_LITERAL: begin
                for (int i = 5; i >= 0; i--) append_run(b[i], 1);
            end
            CHUNK_PAIR: begin
                append_run(b[5], int'(b[4:2]) + 1);
                append_run(~b[5], int'(b[1:0]) + 1);
            end
            default: begin
                append_run(b[6], int'(b[5:0]) + int'(bitrld_pkg::LONG_RUN_BASE));
            end
        endcase
        if (runs_expected.size() > first) begin
            runs_expected[runs_expected.size()-1].last = 1'b1;
            chunks_decoded++;
        end
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Offer one chunk, with random idle cycles ahead of it; predict at the transfer
    task automatic send_chunk(input logic [7:0] b, input logic sof);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_chunk(b, sof);
    endtask

    // Stop offering and wait until every predicted run has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (runs_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_image_size(input logic [15:0] w, input logic [15:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= bitrld_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge i_clk);
        img_width = w;
        cfg_idx  <= bitrld_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge i_clk);
        img_height = h;
        cfg_we   <= 1'b0;
    endtask

    task automatic pick_image_size();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            set_image_size(16'd1, 16'd1);
        else if (r == 1)
            set_image_size(16'($urandom_range(65535, 40)), 16'($urandom_range(3, 1)));
        else
            set_image_size(16'($urandom_range(10, 1)), 16'($urandom_range(5, 1)));
    endtask

    function automatic logic [7:0] random_chunk();
        int r;
        logic [7:0] b;
        r = $urandom_range(9);
        b = 8'($urandom_range(255));
        if (r < 3)      b[7:6] = CHUNK_LITERAL;
        else if (r < 6) b[7:6] = CHUNK_PAIR;
        return b;
    endfunction

    // Receiver: random ready, long hold-off on request, in-order run check
    always @(posedge i_clk) begin
        t_run want;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (runs_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected run data=%h user=%b last=%b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                want = runs_expected.pop_front();
                if (m_axis_tdata[0] !== want.color)
                    report_mismatch($sformatf("run_color %b, want %b",
                                              m_axis_tdata[0], want.color));
                if (m_axis_tdata[7:1] !== want.length)
                    report_mismatch($sformatf("run_length %0d, want %0d",
                                              m_axis_tdata[7:1], want.length));
                if (m_axis_tuser !== want.done)
                    report_mismatch($sformatf("image_done %b, want %b",
                                              m_axis_tuser, want.done));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, want %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    // Reset size is 1x1: one pixel, then the image is complete
    task automatic test_reset_size();
        send_chunk(8'h2a, 1'b0);
        send_chunk(8'hff, 1'b0);
        send_chunk(8'h80, 1'b1);
        send_chunk(8'h5b, 1'b1);
        wait_drained();
    endtask

    // Largest image: no clipping, every chunk type at its field extremes
    task automatic test_chunk_types();
        set_image_size(16'hffff, 16'hffff);
        send_chunk(8'h00, 1'b1);
        send_chunk(8'h3f, 1'b0);
        send_chunk(8'h15, 1'b0);
        send_chunk(8'h40, 1'b0);
        send_chunk(8'h7f, 1'b0);
        send_chunk(8'h63, 1'b0);
        send_chunk(8'h80, 1'b0);
        send_chunk(8'hbf, 1'b0);
        send_chunk(8'hc0, 1'b0);
        send_chunk(8'hff, 1'b0);
        wait_drained();
    endtask

    // Clipping at the image end, bytes past the end, empty images
    task automatic test_clipping();
        set_image_size(16'd5, 16'd2);
        send_chunk(8'hff, 1'b1);
        send_chunk(8'h00, 1'b0);
        send_chunk(8'h15, 1'b1);
        send_chunk(8'h7f, 1'b0);
        send_chunk(8'h2a, 1'b1);
        send_chunk(8'h6d, 1'b0);
        send_chunk(8'h3f, 1'b0);
        wait_drained();
        set_image_size(16'd0, 16'd3);
        send_chunk(8'hff, 1'b1);
        send_chunk(8'h2a, 1'b0);
        wait_drained();
        set_image_size(16'hffff, 16'd0);
        send_chunk(8'h7f, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int rx_stall_pct, input int n);
        int target;
        int r;
        int images;
        send_idle_pct = idle_pct;
        stall_pct     = rx_stall_pct;
        target        = chunks_decoded + n;
        images        = 0;
        pick_image_size();
        while (chunks_decoded < target) begin
            r = $urandom_range(99);
            if (r < 80) begin
                // well-formed image with random content
                send_chunk(random_chunk(), 1'b1);
                for (int k = 0; k < 16 && !image_complete(); k++)
                    send_chunk(random_chunk(), 1'b0);
                images++;
            end else if (r < 88) begin
                repeat ($urandom_range(3, 1)) send_chunk(random_chunk(), 1'b0);
            end else if (r < 96) begin
                // truncated image, the next one restarts mid-stream
                send_chunk(random_chunk(), 1'b1);
                repeat ($urandom_range(2)) send_chunk(random_chunk(), 1'b0);
            end else begin
                send_chunk(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            if (images >= 6) begin
                images = 0;
                wait_drained();
                pick_image_size();
            end else if ($urandom_range(19) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // Hold off the output for a long stretch while chunks keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_image_size(16'hffff, 16'd16);
        hold_left <= 400;
        send_chunk(8'h00, 1'b1);
        repeat (39) send_chunk(random_chunk(), 1'b0);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_chunk_types();
        test_clipping();
        test_random_phase(0, 0, 100);
        test_output_backpressure();
        test_random_phase(81, 0, 100);
        test_random_phase(0, 81, 100);
        test_random_phase(23, 23, 100);

        while (runs_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
